// ----- design/ipuhd_pkg.sv -----
`default_nettype none
package ipuhd_pkg;

    localparam int HDR_BYTES = 20;
    localparam int UDP_END   = 26;
    localparam int PAY_START = 28;

    typedef enum logic [3:0] {
        FID_SUM     = 4'd0,
        FID_VER     = 4'd1,
        FID_IHL     = 4'd2,
        FID_TOS     = 4'd3,
        FID_TOTLEN  = 4'd4,
        FID_PROTO   = 4'd5,
        FID_HDRSUM  = 4'd6,
        FID_SRC     = 4'd7,
        FID_DST     = 4'd8,
        FID_SPORT   = 4'd9,
        FID_DPORT   = 4'd10,
        FID_UDPLEN  = 4'd11,
        FID_PAYLOAD = 4'd12,
        FID_SHORT   = 4'd13,
        FID_END     = 4'd14
    } t_field_id;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        logic        hdr;
        logic        one_vld;
        t_field_id   one_id;
        logic [15:0] one_val;
        logic        cls_vld;
        t_field_id   cls_id;
        logic [31:0] cls_val;
        logic [15:0] sum;
    } t_job;

endpackage
`default_nettype wire

// ----- design/ipuhd_parse.sv -----
`default_nettype none
module ipuhd_parse
    import ipuhd_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output t_job            o_job,
    output t_hdr            o_hdr
);

    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_idx, n_idx;
    logic [15:0]           r_sum, n_sum;
    logic [7:0]            r_hold, n_hold;
    t_hdr                  r_hdr;

    logic                  in_hdr;
    logic                  in_udp;
    logic [COUNT_BITS-1:0] count;
    logic [COUNT_BITS-1:0] udp_off;
    logic [16:0]           s0;
    logic [16:0]           s1;
    logic [15:0]           word;

    always_comb begin
        in_hdr  = r_idx < COUNT_BITS'(HDR_BYTES);
        in_udp  = !in_hdr && (r_idx < COUNT_BITS'(UDP_END));
        word    = {r_hold, i_data_byte};
        s0      = {1'b0, r_sum} + {1'b0, word};
        s1      = {1'b0, s0[15:0]} + {16'd0, s0[16]};
        count   = (r_idx < CountMax) ? r_idx + 1'b1 : CountMax;
        udp_off = r_idx - COUNT_BITS'(HDR_BYTES);

        n_idx  = count;
        n_sum  = r_sum;
        n_hold = r_hold;
        if ((in_hdr || in_udp) && !r_idx[0]) begin
            n_hold = i_data_byte;
        end
        if (in_hdr && r_idx[0]) begin
            n_sum = s1[15:0] + {15'd0, s1[16]};
        end
        if (i_last_byte) begin
            n_idx  = '0;
            n_sum  = '0;
            n_hold = '0;
        end

        o_job.hdr     = r_idx == COUNT_BITS'(HDR_BYTES - 1);
        o_job.sum     = in_hdr && r_idx[0] ? s1[15:0] + {15'd0, s1[16]} : r_sum;
        o_job.one_vld = 1'b0;
        o_job.one_id  = FID_PAYLOAD;
        o_job.one_val = {8'd0, i_data_byte};
        if (in_udp && r_idx[0]) begin
            o_job.one_vld = 1'b1;
            o_job.one_id  = t_field_id'(4'(FID_SPORT) + 4'(udp_off[2:1]));
            o_job.one_val = word;
        end else if (r_idx >= COUNT_BITS'(PAY_START)) begin
            o_job.one_vld = 1'b1;
        end
        o_job.cls_vld = i_last_byte;
        o_job.cls_id  = (r_idx < COUNT_BITS'(HDR_BYTES - 1)) ? FID_SHORT : FID_END;
        o_job.cls_val = {{(32-COUNT_BITS){1'b0}}, count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_sum  <= '0;
            r_hold <= '0;
        end else if (i_accept) begin
            r_idx  <= n_idx;
            r_sum  <= n_sum;
            r_hold <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && in_hdr) begin
            r_hdr[r_idx[4:0]] <= i_data_byte;
        end
    end

    assign o_hdr = r_hdr;

endmodule
`default_nettype wire

// ----- design/ipv4_udp_header_decoder_core.sv -----
`default_nettype none
// channel  direction  handshake            payload
// input    in         i_valid / o_ready    i_data_byte, i_last_byte
// output   out        o_valid / i_ready    o_field_id, o_field_value, o_last_result
//
// One input word is taken per cycle while each word makes at most one result and the output is not stalled.
// Byte 19 queues nine header records, so the input stalls there until the last of them is loaded;
// a last byte adds one close record after any other result, and the input stalls for it as well.
// Results are held in pending registers and leave from an output register.
// Synchronous active-low reset clears the byte count, sum and pending records.
module ipv4_udp_header_decoder_core
    import ipuhd_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_field_id,
    output logic [31:0]      o_field_value,
    output logic             o_last_result
);

    t_job  job;
    t_hdr  hdr;
    t_job  r_job;
    logic  r_hdr_pend, n_hdr_pend;
    logic  r_one_pend, n_one_pend;
    logic  r_cls_pend, n_cls_pend;
    logic [3:0]  r_step, n_step;
    logic        r_o_valid, n_o_valid;
    t_field_id   r_o_id, n_o_id;
    logic [31:0] r_o_value, n_o_value;
    logic        r_o_last, n_o_last;

    logic  accept;
    logic  load;
    logic  pend;
    logic  final_pop;
    logic [31:0] hdr_val;

    ipuhd_parse #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_job       (job),
        .o_hdr       (hdr)
    );

    always_comb begin
        unique case (r_step)
            4'd0:    hdr_val = {16'd0, r_job.sum};
            4'd1:    hdr_val = {28'd0, hdr[0][7:4]};
            4'd2:    hdr_val = {28'd0, hdr[0][3:0]};
            4'd3:    hdr_val = {24'd0, hdr[1]};
            4'd4:    hdr_val = {16'd0, hdr[2], hdr[3]};
            4'd5:    hdr_val = {24'd0, hdr[9]};
            4'd6:    hdr_val = {16'd0, hdr[10], hdr[11]};
            4'd7:    hdr_val = {hdr[12], hdr[13], hdr[14], hdr[15]};
            4'd8:    hdr_val = {hdr[16], hdr[17], hdr[18], hdr[19]};
            default: hdr_val = '0;
        endcase
    end

    always_comb begin
        load      = !r_o_valid || i_ready;
        pend      = r_hdr_pend || r_one_pend || r_cls_pend;
        final_pop = load && (
                    (r_hdr_pend && r_step == 4'(FID_DST) && !r_one_pend && !r_cls_pend) ||
                    (!r_hdr_pend && r_one_pend && !r_cls_pend) ||
                    (!r_hdr_pend && !r_one_pend && r_cls_pend));
        o_ready   = !pend || final_pop;
        accept    = i_valid && o_ready;

        n_hdr_pend = r_hdr_pend;
        n_one_pend = r_one_pend;
        n_cls_pend = r_cls_pend;
        n_step     = r_step;
        n_o_valid  = r_o_valid;
        n_o_id     = r_o_id;
        n_o_value  = r_o_value;
        n_o_last   = r_o_last;

        if (load) begin
            n_o_valid = pend;
            priority if (r_hdr_pend) begin
                n_o_id    = t_field_id'(r_step);
                n_o_value = hdr_val;
                n_o_last  = 1'b0;
                n_step    = r_step + 1'b1;
                if (r_step == 4'(FID_DST)) begin
                    n_hdr_pend = 1'b0;
                end
            end else if (r_one_pend) begin
                n_o_id     = r_job.one_id;
                n_o_value  = {16'd0, r_job.one_val};
                n_o_last   = 1'b0;
                n_one_pend = 1'b0;
            end else if (r_cls_pend) begin
                n_o_id     = r_job.cls_id;
                n_o_value  = r_job.cls_val;
                n_o_last   = 1'b1;
                n_cls_pend = 1'b0;
            end
        end

        if (accept) begin
            n_hdr_pend = job.hdr;
            n_one_pend = job.one_vld;
            n_cls_pend = job.cls_vld;
            n_step     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pend <= 1'b0;
            r_one_pend <= 1'b0;
            r_cls_pend <= 1'b0;
            r_step     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_hdr_pend <= n_hdr_pend;
            r_one_pend <= n_one_pend;
            r_cls_pend <= n_cls_pend;
            r_step     <= n_step;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_id    <= n_o_id;
        r_o_value <= n_o_value;
        r_o_last  <= n_o_last;
        if (accept) begin
            r_job <= job;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_field_id    = r_o_id;
    assign o_field_value = r_o_value;
    assign o_last_result = r_o_last;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import ipuhd_pkg::*;

    localparam int COUNT_BITS  = 16;
    localparam int RAND_WORDS  = 400;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct {
        t_field_id   id;
        logic [31:0] val;
        logic        last;
    } t_rec;

    typedef struct {
        logic [7:0]  b;
        logic        last;
        logic        typed;
        t_field_id   id;
        logic [31:0] val;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_field_id;
    logic [31:0] o_field_value;
    logic        o_last_result;

    ipv4_udp_header_decoder_core #(
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_field_id    (o_field_id),
        .o_field_value (o_field_value),
        .o_last_result (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    logic [COUNT_BITS-1:0] pos_cnt;
    logic [16:0]           run_sum;
    logic [7:0]            hdr_bytes [HDR_BYTES];
    logic [7:0]            hi_byte;

    t_rec  decoded_q [$];
    t_rec  field_q   [$];
    t_row  word_tag_q [$];
    t_row  dir_tab [24];
    logic [7:0] pkt_q [$];

    int    err_count = 0;
    int    cycle_cnt = 0;
    bit    calm = 1'b0;
    bit    hold_req = 1'b0;
    bit    rx_hold = 1'b0;

    task automatic clear_decoder();
        pos_cnt = '0;
        run_sum = '0;
        hi_byte = '0;
        foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    endtask

    task automatic emit(input t_field_id id, input logic [31:0] val, input logic last);
        t_rec r;
        r.id   = id;
        r.val  = val;
        r.last = last;
        decoded_q.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        int unsigned idx;
        int unsigned cnt;
        logic [17:0] s;
        idx = pos_cnt;
        if (idx < HDR_BYTES) begin
            hdr_bytes[idx] = b;
            if (!idx[0]) begin
                hi_byte = b;
            end else begin
                s = run_sum + {hi_byte, b};
                run_sum = s[15:0] + s[17:16];
                run_sum = run_sum[15:0] + run_sum[16];
            end
            if (idx == HDR_BYTES - 1) begin
                emit(FID_SUM, {16'h0, run_sum[15:0]}, 1'b0);
                emit(FID_VER, {28'h0, hdr_bytes[0][7:4]}, 1'b0);
                emit(FID_IHL, {28'h0, hdr_bytes[0][3:0]}, 1'b0);
                emit(FID_TOS, {24'h0, hdr_bytes[1]}, 1'b0);
                emit(FID_TOTLEN, {16'h0, hdr_bytes[2], hdr_bytes[3]}, 1'b0);
                emit(FID_PROTO, {24'h0, hdr_bytes[9]}, 1'b0);
                emit(FID_HDRSUM, {16'h0, hdr_bytes[10], hdr_bytes[11]}, 1'b0);
                emit(FID_SRC, {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]},
                     1'b0);
                emit(FID_DST, {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]},
                     1'b0);
            end
        end else if (idx < UDP_END) begin
            if (!idx[0]) begin
                hi_byte = b;
            end else begin
                emit(t_field_id'(FID_SPORT + ((idx - HDR_BYTES) >> 1)), {16'h0, hi_byte, b},
                     1'b0);
            end
        end else if (idx >= PAY_START) begin
            emit(FID_PAYLOAD, {24'h0, b}, 1'b0);
        end
        cnt = (idx < COUNT_MAX) ? idx + 1 : COUNT_MAX;
        pos_cnt = cnt[COUNT_BITS-1:0];
        if (last) begin
            emit((idx < HDR_BYTES - 1) ? FID_SHORT : FID_END, cnt, 1'b1);
            pos_cnt = '0;
            run_sum = '0;
            hi_byte = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_rec exp_r;
        t_row tag;
        t_rec typed_r;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
        if (!i_rst_n) begin
            clear_decoder();
        end else begin
            if (o_valid && i_ready) begin
                if (field_q.size() == 0) begin
                    $error("unexpected result id %0d value %0h", o_field_id, o_field_value);
                    err_count++;
                end else begin
                    exp_r = field_q.pop_front();
                    if (o_field_id !== exp_r.id) begin
                        $error("field_id exp %0d got %0d", exp_r.id, o_field_id);
                        err_count++;
                    end
                    if (o_field_value !== exp_r.val) begin
                        $error("field_value exp %0h got %0h", exp_r.val, o_field_value);
                        err_count++;
                    end
                    if (o_last_result !== exp_r.last) begin
                        $error("last_result exp %0b got %0b", exp_r.last, o_last_result);
                        err_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                tag = word_tag_q.pop_front();
                decode_byte(i_data_byte, i_last_byte);
                if (tag.typed) begin
                    decoded_q.delete();
                    typed_r.id   = tag.id;
                    typed_r.val  = tag.val;
                    typed_r.last = 1'b1;
                    field_q.push_back(typed_r);
                end else begin
                    while (decoded_q.size() > 0) field_q.push_back(decoded_q.pop_front());
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold) begin
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 16);
        end
    end

    initial begin
        wait (hold_req);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic send_word(input t_row row);
        int gap;
        if (!calm && $urandom_range(0, 99) < 5) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        word_tag_q.push_back(row);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= row.b;
        i_last_byte <= row.last;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    task automatic stop_words();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic build_packet(input int len, input bit shaped);
        logic [19:0] acc;
        logic [15:0] ck;
        pkt_q.delete();
        repeat (len) pkt_q.push_back(8'($urandom));
        if (shaped && len >= HDR_BYTES) begin
            pkt_q[0] = 8'h45;
            pkt_q[2] = 8'(len >> 8);
            pkt_q[3] = 8'(len);
            pkt_q[9] = 8'd17;
            acc = '0;
            for (int w = 0; w < HDR_BYTES / 2; w++) begin
                if (w != 5) acc += {pkt_q[2*w], pkt_q[2*w+1]};
            end
            acc = acc[15:0] + acc[19:16];
            acc = acc[15:0] + acc[19:16];
            ck = ~acc[15:0];
            pkt_q[10] = ck[15:8];
            pkt_q[11] = ck[7:0];
        end
    endtask

    task automatic send_packet();
        t_row row;
        row.typed = 1'b0;
        row.id    = FID_SUM;
        row.val   = '0;
        foreach (pkt_q[i]) begin
            row.b    = pkt_q[i];
            row.last = (i == pkt_q.size() - 1);
            send_word(row);
        end
    endtask

    initial begin
        int rand_words;
        int pkt_no;
        int len;
        int pick;
        dir_tab[0] = '{8'hFF, 1'b1, 1'b1, FID_SHORT, 32'd1};
        dir_tab[1] = '{8'h00, 1'b1, 1'b1, FID_SHORT, 32'd1};
        dir_tab[2] = '{8'h00, 1'b0, 1'b0, FID_SUM, 32'd0};
        dir_tab[3] = '{8'hFF, 1'b1, 1'b1, FID_SHORT, 32'd2};
        for (int i = 0; i < HDR_BYTES; i++) begin
            dir_tab[4+i] = '{8'hFF, (i == HDR_BYTES - 1), 1'b0, FID_SUM, 32'd0};
        end

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_word(dir_tab[i]);

        rand_words = 0;
        pkt_no = 0;
        while (rand_words < RAND_WORDS) begin
            calm = (pkt_no >= 4 && pkt_no < 8);
            pick = $urandom_range(0, 99);
            if (pkt_no == 2) begin
                len = 48;
                hold_req = 1'b1;
            end else if (pick < 20) begin
                len = $urandom_range(1, HDR_BYTES - 1);
            end else if (pick < 35) begin
                len = HDR_BYTES;
            end else if (pick < 55) begin
                len = $urandom_range(HDR_BYTES + 1, PAY_START);
            end else begin
                len = $urandom_range(PAY_START + 1, 48);
            end
            build_packet(len, pick[0] || pick < 20);
            send_packet();
            rand_words += len;
            pkt_no++;
            if (pkt_no == 8) begin
                stop_words();
                while (field_q.size() != 0) @(negedge i_clk);
            end
        end

        stop_words();
        while (field_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (err_count == 0 && field_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
